@@ design/erx_pkg.sv @@
`timescale 1ns / 1ps

package erx_pkg;

    // Raw terminator byte (carriage return)
    localparam logic [7:0] FRAME_END = 8'h0D;

    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [7:0] ESCAPE_VALUE_RESET   = 8'd27;
    localparam logic [7:0] MAX_RAW_LENGTH_RESET = 8'd63;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ESCAPE_VALUE   = 2'd0,
        CFG_MAX_RAW_LENGTH = 2'd1
    } cfg_index_t;

    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_END  = 1'b1
    } item_kind_t;

    typedef struct packed {
        logic [7:0] escape_value;
        logic [7:0] max_raw_length;
    } cfg_t;

    typedef struct packed {
        item_kind_t item_kind;
        logic [7:0] type_byte;
        logic [7:0] data_value;
        logic       was_truncated;
        logic       dangling_escape;
    } result_t;

    typedef struct packed {
        logic    emit;
        result_t result;
    } dec_out_t;

endpackage

@@ design/erx_cfg_regs.sv @@
`timescale 1ns / 1ps

module erx_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [erx_pkg::CFG_INDEX_WIDTH-1:0]  wr_index,
    input  logic [7:0]                           wr_data,
    output erx_pkg::cfg_t                        cfg
);

    erx_pkg::cfg_t cfg_reg;
    erx_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (erx_pkg::cfg_index_t'(wr_index))
                erx_pkg::CFG_ESCAPE_VALUE:   cfg_next.escape_value   = wr_data;
                erx_pkg::CFG_MAX_RAW_LENGTH: cfg_next.max_raw_length = wr_data;
                default:                     cfg_next = cfg_reg; // unknown index: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.escape_value   <= erx_pkg::ESCAPE_VALUE_RESET;
            cfg_reg.max_raw_length <= erx_pkg::MAX_RAW_LENGTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/erx_decoder.sv @@
`timescale 1ns / 1ps

// Frame state and per-byte decode. State moves only when step is high.
module erx_decoder
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         raw_byte,
    input  erx_pkg::cfg_t      cfg,
    output erx_pkg::dec_out_t  dec
);

    logic       type_seen_reg,      type_seen_next;
    logic [7:0] current_type_reg,   current_type_next;
    logic       escape_pending_reg, escape_pending_next;
    logic [7:0] raw_count_reg,      raw_count_next;
    logic       overflowed_reg,     overflowed_next;

    always_comb
    begin
        type_seen_next      = type_seen_reg;
        current_type_next   = current_type_reg;
        escape_pending_next = escape_pending_reg;
        raw_count_next      = raw_count_reg;
        overflowed_next     = overflowed_reg;

        dec.emit                   = 1'b0;
        dec.result.item_kind       = erx_pkg::KIND_DATA;
        dec.result.type_byte       = current_type_reg;
        dec.result.data_value      = raw_byte;
        dec.result.was_truncated   = 1'b0;
        dec.result.dangling_escape = 1'b0;

        if (!type_seen_reg)
        begin
            // zero in type position is skipped
            if (raw_byte != 8'd0)
            begin
                current_type_next = raw_byte;
                type_seen_next    = 1'b1;
            end
        end
        else if (raw_byte == erx_pkg::FRAME_END)
        begin
            dec.emit                   = 1'b1;
            dec.result.item_kind       = erx_pkg::KIND_END;
            dec.result.data_value      = 8'd0;
            dec.result.was_truncated   = overflowed_reg;
            dec.result.dangling_escape = escape_pending_reg;
            type_seen_next      = 1'b0;
            current_type_next   = 8'd0;
            escape_pending_next = 1'b0;
            raw_count_next      = 8'd0;
            overflowed_next     = 1'b0;
        end
        else if (raw_count_reg >= cfg.max_raw_length)
        begin
            overflowed_next = 1'b1;
        end
        else
        begin
            // raw_count < max_raw_length <= 255, so no wrap
            raw_count_next = raw_count_reg + 8'd1;
            if (escape_pending_reg)
            begin
                escape_pending_next   = 1'b0;
                dec.emit              = 1'b1;
                dec.result.data_value = raw_byte ^ cfg.escape_value;
            end
            else if (raw_byte == cfg.escape_value)
            begin
                escape_pending_next = 1'b1;
            end
            else
            begin
                dec.emit = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_seen_reg      <= 1'b0;
            current_type_reg   <= 8'd0;
            escape_pending_reg <= 1'b0;
            raw_count_reg      <= 8'd0;
            overflowed_reg     <= 1'b0;
        end
        else if (step)
        begin
            type_seen_reg      <= type_seen_next;
            current_type_reg   <= current_type_next;
            escape_pending_reg <= escape_pending_next;
            raw_count_reg      <= raw_count_next;
            overflowed_reg     <= overflowed_next;
        end
    end

endmodule

@@ design/escaped_frame_receiver_unit.sv @@
`timescale 1ns / 1ps

// Escaped frame receiver: strips byte-stuffed framing from a raw serial byte
// stream, one raw byte per input request. The first nonzero byte of a frame is
// its type; later bytes are decoded until a raw carriage return ends the frame.
// An escape byte is dropped and the following byte is XORed with escape_value.
// Each decoded byte gives one data result and each frame end gives one
// end-of-frame result carrying the truncation and dangling-escape flags; type
// bytes, escapes, skipped zeros and bytes dropped past max_raw_length give no
// result. Throughput is one byte per clock while no result is stalled: an input
// register feeds a single-pass decoder whose frame state updates as the output
// register is written; a held byte is decoded once the output register is free
// and its result is shown from there on the output ports. The output register
// acts as the skid stage: a new byte is taken while a result waits, and input
// stalls only when both the input and output registers are full and the
// waiting result is not being taken. Configuration registers (index 0
// escape_value, index 1 max_raw_length) are always ready and should be written
// only while the receiver is idle.
module escaped_frame_receiver_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    // raw byte channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           rx_byte,

    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 item_kind,
    output logic [7:0]                           type_byte,
    output logic [7:0]                           data_value,
    output logic                                 was_truncated,
    output logic                                 dangling_escape,

    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [erx_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [7:0]                           cfg_data
);

    erx_pkg::cfg_t     cfg;
    erx_pkg::dec_out_t dec;

    logic            in_valid_reg, in_valid_next;
    logic [7:0]      in_byte_reg;
    logic            out_valid_reg, out_valid_next;
    erx_pkg::result_t out_reg;

    logic out_free;
    logic step;
    logic in_take;

    assign cfg_ready = 1'b1;

    erx_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // output slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;
    // decode the held byte whenever its result (if any) has a place to go
    assign step     = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || step;
    assign in_take  = in_valid && in_ready;

    erx_decoder u_dec
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .raw_byte (in_byte_reg),
        .cfg      (cfg),
        .dec      (dec)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step && dec.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= rx_byte;
        end
        if (step && dec.emit)
        begin
            out_reg <= dec.result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign item_kind       = out_reg.item_kind;
    assign type_byte       = out_reg.type_byte;
    assign data_value      = out_reg.data_value;
    assign was_truncated   = out_reg.was_truncated;
    assign dangling_escape = out_reg.dangling_escape;

endmodule

@@ design/erx_port_checker.sv @@
`timescale 1ns / 1ps

module erx_port_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       item_kind,
    input  logic [7:0] type_byte,
    input  logic [7:0] data_value,
    input  logic       was_truncated,
    input  logic       dangling_escape
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(item_kind)
            && $stable(type_byte) && $stable(data_value)
            && $stable(was_truncated) && $stable(dangling_escape))
        else $error("result changed while stalled");

    // frame flags only ride on end-of-frame results
    a_data_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (item_kind == erx_pkg::KIND_DATA)
            |-> !was_truncated && !dangling_escape)
        else $error("flag set on data result");

    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (item_kind == erx_pkg::KIND_END) |-> data_value == 8'd0)
        else $error("nonzero data on end of frame");

    // out_valid rises only after an accepted request has passed the input and output registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a matching request");

endmodule

bind escaped_frame_receiver_unit erx_port_checker u_port_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .item_kind       (item_kind),
    .type_byte       (type_byte),
    .data_value      (data_value),
    .was_truncated   (was_truncated),
    .dangling_escape (dangling_escape)
);

@@ test/escaped_frame_checker.sv @@
`timescale 1ns / 1ps

module escaped_frame_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic [7:0]                           rx_byte,

    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic                                 item_kind,
    input  logic [7:0]                           type_byte,
    input  logic [7:0]                           data_value,
    input  logic                                 was_truncated,
    input  logic                                 dangling_escape,

    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [erx_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [7:0]                           cfg_data,

    output int                                   fail_count,
    output int                                   outstanding
);

    // register shadow
    logic [7:0] esc_byte = erx_pkg::ESCAPE_VALUE_RESET;
    logic [7:0] max_len  = erx_pkg::MAX_RAW_LENGTH_RESET;

    // frame state
    logic       in_frame   = 1'b0;
    logic [7:0] frame_type = 8'h00;
    logic       esc_armed  = 1'b0;
    logic [7:0] kept_count = 8'h00;
    logic       clipped    = 1'b0;

    erx_pkg::result_t frame_results_q[$];
    int               errors   = 0;
    logic             mismatch = 1'b0;

    task automatic clear_frame();
        in_frame   = 1'b0;
        frame_type = 8'h00;
        esc_armed  = 1'b0;
        kept_count = 8'h00;
        clipped    = 1'b0;
    endtask

    // Decode one raw byte, queue the data byte or frame end it produces.
    task automatic deframe_byte(input logic [7:0] raw);
        erx_pkg::result_t r;
        r = '0;
        r.type_byte = frame_type;
        if (!in_frame)
        begin
            if (raw != 8'h00)
            begin
                frame_type = raw;
                in_frame   = 1'b1;
            end
        end
        else if (raw == erx_pkg::FRAME_END)
        begin
            // terminator wins over escape and length limit
            r.item_kind       = erx_pkg::KIND_END;
            r.was_truncated   = clipped;
            r.dangling_escape = esc_armed;
            frame_results_q.push_back(r);
            clear_frame();
        end
        else if (kept_count >= max_len)
        begin
            clipped = 1'b1;
        end
        else
        begin
            kept_count = kept_count + 8'd1;
            if (esc_armed)
            begin
                esc_armed    = 1'b0;
                r.item_kind  = erx_pkg::KIND_DATA;
                r.data_value = raw ^ esc_byte;
                frame_results_q.push_back(r);
            end
            else if (raw == esc_byte)
            begin
                esc_armed = 1'b1;
            end
            else
            begin
                r.item_kind  = erx_pkg::KIND_DATA;
                r.data_value = raw;
                frame_results_q.push_back(r);
            end
        end
    endtask

    task automatic check_field(input string label, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %h, got %h", $time, label, want, got);
            mismatch = 1'b1;
        end
    endtask

    task automatic check_result();
        erx_pkg::result_t want;
        if (frame_results_q.size() == 0)
        begin
            $display("%0t ns: result with nothing pending: kind %0d type %h data %h",
                     $time, item_kind, type_byte, data_value);
            $display("%0t ns:   trunc %0d esc %0d", $time, was_truncated,
                     dangling_escape);
            errors++;
        end
        else
        begin
            want     = frame_results_q.pop_front();
            mismatch = 1'b0;
            check_field("item_kind", {7'd0, want.item_kind}, {7'd0, item_kind});
            check_field("type_byte", want.type_byte, type_byte);
            check_field("data_value", want.data_value, data_value);
            check_field("was_truncated", {7'd0, want.was_truncated},
                        {7'd0, was_truncated});
            check_field("dangling_escape", {7'd0, want.dangling_escape},
                        {7'd0, dangling_escape});
            if (mismatch)
                errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_byte = erx_pkg::ESCAPE_VALUE_RESET;
            max_len  = erx_pkg::MAX_RAW_LENGTH_RESET;
            clear_frame();
            frame_results_q.delete();
            errors = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // a result never depends on a request taken at the same edge
            if (out_valid && out_ready)
                check_result();
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    erx_pkg::CFG_ESCAPE_VALUE:   esc_byte = cfg_data;
                    erx_pkg::CFG_MAX_RAW_LENGTH: max_len  = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                deframe_byte(rx_byte);
            fail_count  <= errors;
            outstanding <= frame_results_q.size();
        end
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    // No request on any channel for this long means the block is hung.
    localparam int STALL_LIMIT = 2000;

    // Register indexes with no register behind them; writes must be ignored.
    localparam logic [erx_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNMAPPED_A = 2'd2;
    localparam logic [erx_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNMAPPED_B = 2'd3;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;

    logic                                in_valid  = 1'b0;
    logic                                in_ready;
    logic [7:0]                          rx_byte   = 8'h00;

    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic                                item_kind;
    logic [7:0]                          type_byte;
    logic [7:0]                          data_value;
    logic                                was_truncated;
    logic                                dangling_escape;

    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [erx_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = erx_pkg::CFG_ESCAPE_VALUE;
    logic [7:0]                          cfg_data  = 8'h00;

    int                                  fail_count;
    int                                  outstanding;

    int                                  items_sent  = 0;
    int                                  burst_left  = 0;
    int                                  idle_cycles = 0;

    always #4 clk = ~clk;

    escaped_frame_receiver_unit DUT
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .item_kind       (item_kind),
        .type_byte       (type_byte),
        .data_value      (data_value),
        .was_truncated   (was_truncated),
        .dangling_escape (dangling_escape),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Checker sits beside the block: it predicts every result from the
    // accepted requests and scores what comes out.
    escaped_frame_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .item_kind       (item_kind),
        .type_byte       (type_byte),
        .data_value      (data_value),
        .was_truncated   (was_truncated),
        .dangling_escape (dangling_escape),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding)
    );

    // ------------------------------------------------------------------
    // Sender side. Every task is entered right at a rising edge; send_raw
    // returns at the edge where its request was taken.
    // ------------------------------------------------------------------

    // One raw byte. The sender runs in bursts; between bursts valid drops
    // for a random gap (sometimes none, so back-to-back bursts also occur).
    task automatic send_raw(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(60, 200);
            else
                burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        rx_byte  <= b;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Let the pipe empty out: bytes that make no result may still be in
    // flight, so wait a few cycles on both sides of the drain.
    task automatic drain();
        in_valid <= 1'b0;
        repeat (4) @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [erx_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [7:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // A well-formed frame with random content: optional leading zeros, a
    // type byte, a body mixing plain bytes and escape pairs, an optional
    // dangling escape, then the terminator. The escape value is the one
    // currently programmed.
    task automatic send_frame(input logic [7:0] esc, input int body, input bit dangle);
        logic [7:0] b;
        int         pick;
        int         k;
        bit         can_escape;
        can_escape = (esc != erx_pkg::FRAME_END);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) send_raw(8'h00);
        // carriage return is a legal type byte
        if ($urandom_range(0, 15) == 0)
            b = erx_pkg::FRAME_END;
        else
            b = 8'($urandom_range(1, 255));
        send_raw(b);
        for (k = 0; k < body; k++)
        begin
            pick = $urandom_range(0, 9);
            if (can_escape && pick < 2)
            begin
                // escape plus random payload byte
                send_raw(esc);
                b = 8'($urandom_range(0, 255));
                if (b == erx_pkg::FRAME_END)
                    b = ~b;
                send_raw(b);
            end
            else if (can_escape && esc != 8'h00 && pick == 2)
            begin
                // escaped carriage return decodes to 0x0D data
                send_raw(esc);
                send_raw(esc ^ erx_pkg::FRAME_END);
            end
            else if (can_escape && pick == 3)
            begin
                // escaped escape decodes to zero
                send_raw(esc);
                send_raw(esc);
            end
            else
            begin
                b = 8'($urandom_range(0, 255));
                if (b == erx_pkg::FRAME_END || b == esc)
                    b = b ^ 8'h40;
                send_raw(b);
            end
        end
        if (dangle && can_escape)
            send_raw(esc);
        send_raw(erx_pkg::FRAME_END);
    endtask

    // One configuration setting and its share of random traffic. Mostly
    // frames, with bursts of raw noise that break framing now and then.
    task automatic run_phase(input logic [7:0] esc, input logic [7:0] limit, input int n_items);
        int stop_at;
        int pick;
        int body;
        drain();
        cfg_write(erx_pkg::CFG_ESCAPE_VALUE, esc);
        cfg_write(erx_pkg::CFG_MAX_RAW_LENGTH, limit);
        stop_at = items_sent + n_items;
        // large limits: one frame past the limit, the rest stay short
        if (limit > 16)
            send_frame(esc, limit + $urandom_range(1, 4), 1'b0);
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 2)
            begin
                repeat ($urandom_range(1, 6)) send_raw(8'($urandom_range(0, 255)));
            end
            else
            begin
                if (limit <= 16 && pick < 6)
                    body = limit + $urandom_range(0, 3);
                else
                    body = $urandom_range(0, 12);
                send_frame(esc, body, $urandom_range(0, 9) == 0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Writes to unmapped indexes must leave the reset values alone,
        // which the first directed frames rely on.
        cfg_write(CFG_UNMAPPED_A, 8'($urandom_range(0, 255)));
        cfg_write(CFG_UNMAPPED_B, 8'($urandom_range(0, 255)));

        // Reset config: escape 0x1B, limit 63.
        send_raw(8'h00);                        // zero in type slot, skipped
        send_raw(erx_pkg::FRAME_END);           // CR taken as type
        send_raw(8'h00);
        send_raw(8'hFF);
        send_raw(erx_pkg::ESCAPE_VALUE_RESET);
        send_raw(erx_pkg::FRAME_END);           // ends frame, escape dangling
        send_raw(8'hFF);
        send_raw(erx_pkg::ESCAPE_VALUE_RESET);
        send_raw(erx_pkg::ESCAPE_VALUE_RESET);  // escaped escape -> 0x00
        send_raw(erx_pkg::ESCAPE_VALUE_RESET);
        send_raw(erx_pkg::ESCAPE_VALUE_RESET ^ erx_pkg::FRAME_END); // escaped CR -> 0x0D
        send_raw(erx_pkg::FRAME_END);

        // Limit of 2: escape stays armed across the dropped byte.
        drain();
        cfg_write(erx_pkg::CFG_MAX_RAW_LENGTH, 8'd2);
        send_raw(8'h41);
        send_raw(8'h01);
        send_raw(erx_pkg::ESCAPE_VALUE_RESET);
        send_raw(8'h55);                        // past limit, dropped
        send_raw(erx_pkg::FRAME_END);           // truncated and dangling

        // Limit of 0 and escape equal to the terminator.
        drain();
        cfg_write(erx_pkg::CFG_ESCAPE_VALUE, erx_pkg::FRAME_END);
        cfg_write(erx_pkg::CFG_MAX_RAW_LENGTH, 8'd0);
        send_raw(8'h80);
        send_raw(erx_pkg::FRAME_END);           // empty frame, not truncated
        send_raw(8'h7F);
        send_raw(8'h33);
        send_raw(erx_pkg::FRAME_END);

        // Escape of zero, widest limit.
        drain();
        cfg_write(erx_pkg::CFG_ESCAPE_VALUE, 8'h00);
        cfg_write(erx_pkg::CFG_MAX_RAW_LENGTH, 8'hFF);
        send_raw(8'h01);
        send_raw(8'h00);
        send_raw(8'h00);
        send_raw(erx_pkg::FRAME_END);

        // Random traffic over a spread of settings, extremes included.
        run_phase(erx_pkg::ESCAPE_VALUE_RESET, erx_pkg::MAX_RAW_LENGTH_RESET, 100);
        run_phase(8'hFF, 8'd254, 200);
        run_phase(8'h00, 8'd1, 100);
        run_phase(erx_pkg::FRAME_END, 8'd8, 80);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(1, 254)), 100);
        run_phase(8'($urandom_range(0, 255)), 8'd255, 150);
        run_phase(8'h80, 8'd0, 60);
        run_phase(erx_pkg::ESCAPE_VALUE_RESET, 8'd3, 80);

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver side: random stall modes that change every so often, plus
    // two long hold-offs while the sender keeps pushing, so the output
    // and input registers fill and in_ready drops.
    // ------------------------------------------------------------------
    initial
    begin
        int mode;
        int span;
        int taken;
        int next_hold;
        int cyc;
        taken     = 0;
        next_hold = 150;
        cyc       = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(posedge clk);
                cyc++;
                if (out_valid && out_ready)
                    taken++;
                if (taken >= next_hold)
                begin
                    out_ready <= 1'b0;
                    repeat (300) @(posedge clk);
                    next_hold = (next_hold == 150) ? 500 : 32'h7fffffff;
                end
                else
                begin
                    case (mode)
                        0: out_ready <= 1'b1;
                        1: out_ready <= ($urandom_range(0, 3) != 0);
                        2: out_ready <= ($urandom_range(0, 3) == 0);
                        default: out_ready <= (cyc % 3 == 0);
                    endcase
                end
            end
        end
    end

    // Watchdog: count cycles with no request taken on any channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule

@@ escaped_frame_receiver_unit.f @@
design/erx_pkg.sv
design/erx_cfg_regs.sv
design/erx_decoder.sv
design/escaped_frame_receiver_unit.sv
design/erx_port_checker.sv
test/escaped_frame_checker.sv
test/testbench.sv
